[rtl/dual_quadrature_counter_with_speed_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dual quadrature counter
// Shared concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_QUADRATURE_COUNTER_WITH_SPEED_ASSERT_SVH
`define DUAL_QUADRATURE_COUNTER_WITH_SPEED_ASSERT_SVH

// same-cycle implication
`define DQC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DQC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dqc_pkg.sv]
// ----------------------------------------------------------------------------
// dqc_pkg
// Types, widths and register codes for the dual quadrature counter.
// ----------------------------------------------------------------------------
package dqc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int OUT_W       = 16;
    localparam int ELAPSED_W   = 17;
    localparam int WINDOW_W    = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [WINDOW_W-1:0]  WINDOW_RESET = WINDOW_W'(20);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = {ELAPSED_W{1'b1}};

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_WINDOW_MS    = 2'd0,
        REG_NEGATE_LEFT  = 2'd1,
        REG_NEGATE_RIGHT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [WINDOW_W-1:0] window_ms;
        logic                negate_left;
        logic                negate_right;
    } cfg_t;

    typedef struct packed {
        logic [OUT_W-1:0] right_speed;
        logic [OUT_W-1:0] left_speed;
        logic [OUT_W-1:0] right_position;
        logic [OUT_W-1:0] left_position;
        logic             speed_updated;
    } result_t;

    // low OUT_W bits of a count, zero-filled when the count is narrower
    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+OUT_W-1:0] ext;
        ext = {{OUT_W{1'b0}}, v};
        return ext[OUT_W-1:0];
    endfunction

endpackage

[rtl/dqc_regs.sv]
// ----------------------------------------------------------------------------
// dqc_regs
// APB register file: window length and per-encoder direction inversion.
// ----------------------------------------------------------------------------
module dqc_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dqc_pkg::ADDR_W-1:0] paddr,
    input  logic [dqc_pkg::DATA_W-1:0] pwdata,
    output logic [dqc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output dqc_pkg::cfg_t              cfg
);
    import dqc_pkg::*;

    logic [WINDOW_W-1:0] window_ms_reg;
    logic                negate_left_reg;
    logic                negate_right_reg;
    logic                wr_en;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg    <= WINDOW_RESET;
            negate_left_reg  <= 1'b0;
            negate_right_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_WINDOW_MS:    window_ms_reg    <= pwdata[WINDOW_W-1:0];
                REG_NEGATE_LEFT:  negate_left_reg  <= pwdata[0];
                REG_NEGATE_RIGHT: negate_right_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_WINDOW_MS:    prdata = {{(DATA_W-WINDOW_W){1'b0}}, window_ms_reg};
            REG_NEGATE_LEFT:  prdata = {{(DATA_W-1){1'b0}}, negate_left_reg};
            REG_NEGATE_RIGHT: prdata = {{(DATA_W-1){1'b0}}, negate_right_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.window_ms    = window_ms_reg;
    assign cfg.negate_left  = negate_left_reg;
    assign cfg.negate_right = negate_right_reg;

endmodule

[rtl/dqc_channel.sv]
// ----------------------------------------------------------------------------
// dqc_channel
// One encoder: A-edge up/down count, window snapshot and latched speed.
// ----------------------------------------------------------------------------
module dqc_channel (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      a,
    input  logic                      b,
    input  logic                      negate,
    input  logic                      latch,
    output logic [dqc_pkg::OUT_W-1:0] position,
    output logic [dqc_pkg::OUT_W-1:0] speed
);
    import dqc_pkg::*;

    logic                   prev_a_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] snap_reg;
    logic [COUNT_WIDTH-1:0] rate_reg;
    logic [COUNT_WIDTH-1:0] rate_next;
    logic                   up;

    assign up = (a ^ b) ^ negate;

    always_comb
    begin
        count_next = count_reg;
        if (a != prev_a_reg)
            count_next = up ? count_reg + COUNT_WIDTH'(1) : count_reg - COUNT_WIDTH'(1);
        rate_next = latch ? count_next - snap_reg : rate_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg <= 1'b0;
            count_reg  <= '0;
            snap_reg   <= '0;
            rate_reg   <= '0;
        end
        else if (en)
        begin
            prev_a_reg <= a;
            count_reg  <= count_next;
            rate_reg   <= rate_next;
            if (latch)
                snap_reg <= count_next;
        end
    end

    assign position = to_out(count_next);
    assign speed    = to_out(rate_next);

endmodule

[rtl/dqc_window.sv]
// ----------------------------------------------------------------------------
// dqc_window
// Millisecond elapsed counter; flags the item on which speeds are latched.
// ----------------------------------------------------------------------------
`include "dual_quadrature_counter_with_speed_assert.svh"

module dqc_window (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         tick,
    input  logic [dqc_pkg::WINDOW_W-1:0] window_ms,
    output logic                         latch
);
    import dqc_pkg::*;

    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ELAPSED_W-1:0] elapsed_next;

    always_comb
    begin
        elapsed_inc = elapsed_reg;
        if (tick && elapsed_reg != ELAPSED_MAX)
            elapsed_inc = elapsed_reg + ELAPSED_W'(1);
        latch        = elapsed_inc > {{(ELAPSED_W-WINDOW_W){1'b0}}, window_ms};
        elapsed_next = latch ? '0 : elapsed_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            elapsed_reg <= '0;
        else if (en)
            elapsed_reg <= elapsed_next;
    end

    `DQC_ASSERT_NXT(a_latch_clears, en && latch, elapsed_reg == '0, "elapsed not cleared")
    `DQC_ASSERT_NXT(a_idle_holds, !en, $stable(elapsed_reg), "elapsed moved without item")

endmodule

[rtl/dqc_out_buf.sv]
// ----------------------------------------------------------------------------
// dqc_out_buf
// Two-entry output stage: output register plus skid register.
// ----------------------------------------------------------------------------
`include "dual_quadrature_counter_with_speed_assert.svh"

module dqc_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dqc_pkg::result_t push_data,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output dqc_pkg::result_t out_data
);
    import dqc_pkg::*;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign pop      = main_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            main_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    `DQC_ASSERT_IMP(a_skid_needs_main, skid_valid_reg, main_valid_reg, "skid without main")
    `DQC_ASSERT_NXT(a_stall_holds, main_valid_reg && !out_ready,
        main_valid_reg && $stable(main_reg), "stalled result changed")

endmodule

[rtl/dual_quadrature_counter_with_speed.sv]
// An accepted sample's result is registered in the output or the skid register.
// Throughput: one sample per cycle; s_tready drops only while both the output
// register and the skid register hold results that m_tready has not taken.
// Counts and the window check are combinational: adders and a 17-bit compare.
// Reset (rst_n low, async): counts, snapshots, speeds, elapsed cleared;
// window_ms returns to 20, negate bits to 0; no result pending.
// ----------------------------------------------------------------------------
// dual_quadrature_counter_with_speed
// Two quadrature encoder counters with windowed speed measurement.
// ----------------------------------------------------------------------------
module dual_quadrature_counter_with_speed (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,  // left_a, left_b, right_a, right_b, pad
    input  logic                       s_tuser,  // ms_tick
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,  // left_position, right_position,
                                                 // left_speed, right_speed
    output logic                       m_tuser,  // speed_updated
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dqc_pkg::ADDR_W-1:0] paddr,
    input  logic [dqc_pkg::DATA_W-1:0] pwdata,
    output logic [dqc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import dqc_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_res;
    logic    accept;
    logic    latch;

    assign accept = s_tvalid && s_tready;

    dqc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dqc_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (accept),
        .tick      (s_tuser),
        .window_ms (cfg.window_ms),
        .latch     (latch)
    );

    dqc_channel u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .a        (s_tdata[0]),
        .b        (s_tdata[1]),
        .negate   (cfg.negate_left),
        .latch    (latch),
        .position (res.left_position),
        .speed    (res.left_speed)
    );

    dqc_channel u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept),
        .a        (s_tdata[2]),
        .b        (s_tdata[3]),
        .negate   (cfg.negate_right),
        .latch    (latch),
        .position (res.right_position),
        .speed    (res.right_speed)
    );

    assign res.speed_updated = latch;

    dqc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.right_speed, out_res.left_speed,
                      out_res.right_position, out_res.left_position};
    assign m_tuser = out_res.speed_updated;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives encoder samples into the dual quadrature counter over its stream
// port, changes the window and direction registers over APB while the block
// is idle, and checks every result against the table values of typed directed rows
// or an in-bench model of the counts, the elapsed-ms window and the latched speeds.
// ----------------------------------------------------------------------------
module testbench;
    import dqc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 75;
    localparam int SWEEP_ITEMS = 80;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        la;
        logic        lb;
        logic        ra;
        logic        rb;
        logic        tick;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        typed;
        result_t     want;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;  // left_a, left_b, right_a, right_b, pad
    logic              s_tuser = 1'b0;  // ms_tick
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [63:0]       m_tdata;  // left_position, right_position, left_speed, right_speed
    logic              m_tuser;  // speed_updated
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dual_quadrature_counter_with_speed dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow registers
    logic [WINDOW_W-1:0] win_ms = WINDOW_RESET;
    logic                neg_left = 1'b0;
    logic                neg_right = 1'b0;

    // model state
    logic                 last_la = 1'b0;
    logic                 last_ra = 1'b0;
    logic [15:0]          left_pos = '0;
    logic [15:0]          right_pos = '0;
    logic [15:0]          left_mark = '0;
    logic [15:0]          right_mark = '0;
    logic [15:0]          left_rate = '0;
    logic [15:0]          right_rate = '0;
    logic [ELAPSED_W-1:0] elapsed = '0;

    result_t pending_results[$];
    int      errors = 0;
    int      gap_pct = 0;
    int      stall_pct = 0;
    logic    hold_req = 1'b0;
    logic    row_typed = 1'b0;
    result_t row_want = '0;
    row_t    directed[$];

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < 100)
            $display("mismatch: %s got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic logic [15:0] step_position(input logic [15:0] cnt, input logic a,
                                                  input logic b, input logic prev_a,
                                                  input logic neg);
        logic up;
        up = (a != b) ^ neg;
        if (a == prev_a)
            return cnt;
        return up ? cnt + 16'd1 : cnt - 16'd1;
    endfunction

    // counts first, then the tick, then the window check
    task automatic count_and_latch(input logic [3:0] levels, input logic tick,
                                   output result_t r);
        left_pos  = step_position(left_pos, levels[0], levels[1], last_la, neg_left);
        right_pos = step_position(right_pos, levels[2], levels[3], last_ra, neg_right);
        last_la = levels[0];
        last_ra = levels[2];
        if (tick && elapsed != ELAPSED_MAX)
            elapsed = elapsed + 1'b1;
        r.speed_updated = 1'b0;
        if (elapsed > {1'b0, win_ms}) begin
            left_rate  = left_pos - left_mark;
            right_rate = right_pos - right_mark;
            left_mark  = left_pos;
            right_mark = right_pos;
            elapsed = '0;
            r.speed_updated = 1'b1;
        end
        r.left_position  = left_pos;
        r.right_position = right_pos;
        r.left_speed     = left_rate;
        r.right_speed    = right_rate;
    endtask

    // results out, then requests in, both sampled at the edge
    always @(posedge clk) begin : monitor
        result_t got;
        result_t want;
        result_t pred;
        if (m_tvalid && m_tready) begin
            got.left_position  = m_tdata[15:0];
            got.right_position = m_tdata[31:16];
            got.left_speed     = m_tdata[47:32];
            got.right_speed    = m_tdata[63:48];
            got.speed_updated  = m_tuser;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", m_tdata[15:0], 0);
            end
            else begin
                want = pending_results.pop_front();
                if (got.left_position !== want.left_position)
                    report_mismatch("left_position", got.left_position, want.left_position);
                if (got.right_position !== want.right_position)
                    report_mismatch("right_position", got.right_position,
                                    want.right_position);
                if (got.left_speed !== want.left_speed)
                    report_mismatch("left_speed", got.left_speed, want.left_speed);
                if (got.right_speed !== want.right_speed)
                    report_mismatch("right_speed", got.right_speed, want.right_speed);
                if (got.speed_updated !== want.speed_updated)
                    report_mismatch("speed_updated", got.speed_updated, want.speed_updated);
            end
        end
        if (s_tvalid && s_tready) begin
            count_and_latch(s_tdata[3:0], s_tuser, pred);
            pending_results.push_back(row_typed ? row_want : pred);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk) begin : receiver
        int hold_left;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin : watchdog
        int quiet;
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("[dual_quadrature_counter_with_speed] ERROR");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic la, input logic lb, input logic ra,
                               input logic rb, input logic tick, input logic typed,
                               input result_t want);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {4'b0, rb, ra, lb, la};
        s_tuser   <= tick;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge clk); while (!s_tready);
    endtask

    // stop offering and let every pending request come back
    task automatic drain;
        s_tvalid <= 1'b0;
        // the last accepted request is queued by the monitor at the same edge
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WINDOW_MS:    win_ms = value[WINDOW_W-1:0];
            REG_NEGATE_LEFT:  neg_left = value[0];
            REG_NEGATE_RIGHT: neg_right = value[0];
            default: ;
        endcase
    endtask

    function automatic result_t res(input logic [15:0] lp, input logic [15:0] rp,
                                    input logic [15:0] ls, input logic [15:0] rs,
                                    input logic upd);
        result_t r;
        r.left_position  = lp;
        r.right_position = rp;
        r.left_speed     = ls;
        r.right_speed    = rs;
        r.speed_updated  = upd;
        return r;
    endfunction

    function automatic row_t sample_row(input logic la, input logic lb, input logic ra,
                                        input logic rb, input logic tick, input logic typed,
                                        input result_t want);
        row_t r;
        r = '0;
        r.kind = ROW_SAMPLE;
        {r.la, r.lb, r.ra, r.rb, r.tick} = {la, lb, ra, rb, tick};
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic row_t write_row(input logic [1:0] idx, input logic [31:0] value);
        row_t r;
        r = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    task automatic load_directed;
        // no edge out of reset
        directed.push_back(sample_row(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
            res(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0)));
        // first sample with A high counts as an edge: left up, right down
        directed.push_back(sample_row(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
            res(16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 1'b0)));
        directed.push_back(sample_row(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
            res(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0)));
        // zero window: latch on the first tick
        directed.push_back(write_row(REG_WINDOW_MS, 32'd0));
        directed.push_back(sample_row(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
            res(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1)));
        directed.push_back(sample_row(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
            res(16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b0)));
        directed.push_back(sample_row(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
            res(16'h0002, 16'h0002, 16'h0002, 16'h0002, 1'b1)));
        directed.push_back(write_row(REG_NEGATE_LEFT, 32'd1));
        directed.push_back(sample_row(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        directed.push_back(write_row(REG_NEGATE_RIGHT, 32'd1));
        directed.push_back(sample_row(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0));
        directed.push_back(sample_row(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '0));
        // upper bits of pwdata are dropped
        directed.push_back(write_row(REG_WINDOW_MS, 32'hFFFF_FFFF));
        directed.push_back(write_row(REG_NEGATE_LEFT, 32'hFFFF_FFFE));
        directed.push_back(write_row(REG_NEGATE_RIGHT, 32'hFFFF_FFFE));
        // unmapped register: ignored
        directed.push_back(write_row(REG_UNMAPPED, 32'hFFFF_FFFF));
        directed.push_back(sample_row(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0));
        directed.push_back(sample_row(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0));
        directed.push_back(write_row(REG_WINDOW_MS, 32'd1));
        directed.push_back(sample_row(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0));
        directed.push_back(sample_row(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, '0));
        directed.push_back(sample_row(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0));
        directed.push_back(sample_row(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, '0));
    endtask

    // gray-code position to (A, B); forward order counts up on A edges
    function automatic logic [1:0] gray_ab(input logic [1:0] ph);
        case (ph)
            2'd0:    return 2'b00;
            2'd1:    return 2'b10;
            2'd2:    return 2'b11;
            default: return 2'b01;
        endcase
    endfunction

    initial begin : stimulus
        logic [1:0] lph;
        logic [1:0] rph;
        logic [1:0] lab;
        logic [1:0] rab;
        logic [3:0] noise;
        logic       tick;
        int         tick_pct;
        row_t       row;

        lph = '0;
        rph = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_directed();
        foreach (directed[i]) begin
            row = directed[i];
            if (row.kind == ROW_WRITE) begin
                drain();
                apb_write(row.reg_idx, row.value);
            end
            else begin
                send_sample(row.la, row.lb, row.ra, row.rb, row.tick, row.typed, row.want);
            end
        end
        drain();

        // random walks per idling phase: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            gap_pct   = (ph == 1) ? 72 : (ph == 3) ? 16 : 0;
            stall_pct = (ph == 2) ? 72 : (ph == 3) ? 16 : 0;
            apb_write(REG_WINDOW_MS, (ph == 3) ? 32'd0 : $urandom_range(0, 8));
            apb_write(REG_NEGATE_LEFT, $urandom);
            apb_write(REG_NEGATE_RIGHT, $urandom);
            tick_pct = $urandom_range(20, 60);
            if (ph == 0)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 15) begin
                    noise = 4'($urandom);
                    lab = noise[1:0];
                    rab = noise[3:2];
                end
                else begin
                    lph = lph + 2'($urandom_range(0, 2) - 1);
                    rph = rph + 2'($urandom_range(0, 2) - 1);
                    lab = gray_ab(lph);
                    rab = gray_ab(rph);
                end
                tick = ($urandom_range(0, 99) < tick_pct);
                send_sample(lab[1], lab[0], rab[1], rab[0], tick, 1'b0, '0);
            end
        end

        // steady sweep: left runs up and right runs down
        drain();
        gap_pct   = 0;
        stall_pct = 0;
        apb_write(REG_WINDOW_MS, 32'd200);
        apb_write(REG_NEGATE_LEFT, 32'd0);
        apb_write(REG_NEGATE_RIGHT, 32'd0);
        for (int n = 0; n < SWEEP_ITEMS; n++) begin
            lph = lph + 2'd1;
            rph = rph - 2'd1;
            lab = gray_ab(lph);
            rab = gray_ab(rph);
            tick = ($urandom_range(0, 15) == 0);
            send_sample(lab[1], lab[0], rab[1], rab[0], tick, 1'b0, '0);
        end

        drain();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("requests without result", pending_results.size(), 0);
        if (errors == 0)
            $display("[dual_quadrature_counter_with_speed] OK");
        else
            $display("[dual_quadrature_counter_with_speed] ERROR");
        $finish;
    end

endmodule
